### rtl/core/pol_pkg.sv
// Shared types and codes for the positional ordered list.
// No dependencies; used by every module under rtl/core.
`default_nettype none

package pol_pkg;

  // Width of one list entry
  localparam int unsigned WordW = 32;
  // Width of the position and count fields on the stream words
  localparam int unsigned PosW = 7;

  // Request codes carried in the command field
  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_READ   = 2'd2
  } cmd_t;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_RANGE = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_COLLECT
  } state_t;

  // Control broadcast to every cell of the chain
  typedef struct packed {
    logic            ins;  // shift back from idx, load new value at idx
    logic            del;  // shift forward from idx
    logic [PosW-1:0] idx;  // 0-based target position
  } pol_ctrl_t;

endpackage

`default_nettype wire

### rtl/core/pol_cell.sv
// One cell of the list chain: holds a single entry and trades it with its neighbors.
// Depends on pol_pkg.
`default_nettype none

module pol_cell #(
  parameter int unsigned INDEX = 0
) (
  input  wire logic                      clk,
  input  wire logic                      en,
  input  wire pol_pkg::pol_ctrl_t        ctrl,
  input  wire logic [pol_pkg::WordW-1:0] new_value,
  input  wire logic [pol_pkg::WordW-1:0] prev_data,
  input  wire logic [pol_pkg::WordW-1:0] next_data,
  output logic      [pol_pkg::WordW-1:0] data,
  output logic      [pol_pkg::WordW-1:0] tap
);
  import pol_pkg::*;

  localparam logic [31:0] Index32 = INDEX;

  logic [31:0] idx32;
  logic        hit;
  logic        after;

  // Position of this cell relative to the target
  assign idx32 = {{(32-PosW){1'b0}}, ctrl.idx};
  assign hit   = (idx32 == Index32);
  assign after = (Index32 > idx32);

  // Entry register: keep, take neighbor, or take the new word
  always_ff @(posedge clk) begin
    if (en) begin
      if (ctrl.ins) begin
        if (hit) begin
          data <= new_value;
        end else if (after) begin
          data <= prev_data;
        end
      end else if (ctrl.del) begin
        if (hit || after) begin
          data <= next_data;
        end
      end
    end
  end

  // Read tap: only the addressed cell drives its entry
  assign tap = hit ? data : '0;

endmodule

`default_nettype wire

### rtl/core/pol_group.sv
// Registered OR stage over a slice of cell taps (at most one tap is nonzero).
// Depends on pol_pkg.
`default_nettype none

module pol_group #(
  parameter int unsigned N = 32
) (
  input  wire logic                               clk,
  input  wire logic                               en,
  input  wire logic [N-1:0][pol_pkg::WordW-1:0]   taps,
  output logic      [pol_pkg::WordW-1:0]          merged
);
  import pol_pkg::*;

  logic [WordW-1:0] merged_next;

  // Fold the slice
  always_comb begin
    merged_next = '0;
    for (int i = 0; i < N; i++) begin
      merged_next = merged_next | taps[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      merged <= merged_next;
    end
  end

endmodule

`default_nettype wire

### rtl/core/positional_ordered_list.sv
// Top level of the positional ordered list: sequencer, chain of cells, read taps.
// Depends on pol_pkg, pol_cell and pol_group.
//
//  channel | dir | handshake          | tdata fields (lsb first)
//  s_*     | in  | s_tvalid/s_tready  | command[1:0] position[8:2] value[40:9]
//  m_*     | out | m_tvalid/m_tready  | read_value[31:0] status[33:32] entry_count[40:34]
//
// Each word goes through accept and check in ST_IDLE, then ST_EXEC, in which every
// cell shifts or holds and the read taps are merged per group of 32 cells, then
// ST_COLLECT, which does the final merge into the output register.
// A stalled output keeps the next word parked in ST_COLLECT; a new word
// is still accepted while a finished result waits on m_tvalid.
// Reset empties the list; entries themselves are not cleared.
`default_nettype none

module positional_ordered_list #(
  parameter int unsigned DEPTH = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [47:0] s_tdata,   // command[1:0], position[8:2], value[40:9], zero pad
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [47:0] m_tdata    // read_value[31:0], status[33:32], entry_count[40:34], pad
);
  import pol_pkg::*;

  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned CMPW = ((CW > PosW) ? CW : PosW) + 1;
  localparam int unsigned GS   = 32;
  localparam int unsigned NG   = (DEPTH + GS - 1) / GS;

  state_t state, state_next;

  logic [CW-1:0]    count;
  logic [CW-1:0]    count_next;

  // Captured request
  pol_ctrl_t        op_ctrl;
  logic             op_rd;
  status_t          op_status;
  logic [WordW-1:0] op_value;

  // Handshake and sequencing strobes
  logic accept;
  logic cell_en;
  logic out_load;

  // Request decode
  cmd_t             in_cmd;
  logic [PosW-1:0]  in_pos;
  logic [CMPW-1:0]  pos_w;
  logic [CMPW-1:0]  cnt_w;
  logic             full;
  status_t          dec_status;
  pol_ctrl_t        dec_ctrl;
  logic             dec_rd;

  // Chain
  logic [DEPTH-1:0][WordW-1:0] cell_data;
  logic [DEPTH-1:0][WordW-1:0] cell_tap;
  logic [NG-1:0][WordW-1:0]    grp_data;
  logic [WordW-1:0]            read_merged;
  logic [WordW-1:0]            read_value;

  assign accept = s_tvalid && s_tready;
  assign in_cmd = cmd_t'(s_tdata[1:0]);
  assign in_pos = s_tdata[8:2];
  assign pos_w  = CMPW'(in_pos);
  assign cnt_w  = CMPW'(count);
  assign full   = (count == CW'(DEPTH));

  // Range and capacity checks; flagged requests change nothing
  always_comb begin
    dec_status   = STAT_OK;
    dec_ctrl.ins = 1'b0;
    dec_ctrl.del = 1'b0;
    dec_ctrl.idx = in_pos - PosW'(1);
    dec_rd       = 1'b0;
    case (in_cmd)
      CMD_INSERT: begin
        if (full) begin
          dec_status = STAT_FULL;
        end else if (in_pos == '0 || pos_w > cnt_w + CMPW'(1)) begin
          dec_status = STAT_RANGE;
        end else begin
          dec_ctrl.ins = 1'b1;
        end
      end
      CMD_DELETE, CMD_READ: begin
        if (in_pos == '0 || pos_w > cnt_w) begin
          dec_status = STAT_RANGE;
        end else begin
          dec_ctrl.del = (in_cmd == CMD_DELETE);
          dec_rd       = 1'b1;
        end
      end
      default: begin
        dec_status = STAT_RANGE;
      end
    endcase
  end

  // Request capture
  always_ff @(posedge clk) begin
    if (accept) begin
      op_ctrl   <= dec_ctrl;
      op_rd     <= dec_rd;
      op_status <= dec_status;
      op_value  <= s_tdata[40:9];
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:    if (accept) state_next = ST_EXEC;
      ST_EXEC:    state_next = ST_COLLECT;
      ST_COLLECT: if (out_load) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    s_tready = 1'b0;
    cell_en  = 1'b0;
    out_load = 1'b0;
    case (state)
      ST_IDLE:    s_tready = 1'b1;
      ST_EXEC:    cell_en  = 1'b1;
      ST_COLLECT: out_load = !m_tvalid || m_tready;
      default:    ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Entry count
  always_comb begin
    count_next = count;
    if (cell_en && op_ctrl.ins) begin
      count_next = count + CW'(1);
    end else if (cell_en && op_ctrl.del) begin
      count_next = count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // Chain of cells, each wired to its two neighbors
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WordW-1:0] prev_d;
    logic [WordW-1:0] next_d;
    if (i == 0) begin : g_head
      assign prev_d = op_value;
    end else begin : g_mid
      assign prev_d = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign next_d = '0;
    end else begin : g_body
      assign next_d = cell_data[i+1];
    end
    pol_cell #(
      .INDEX (i)
    ) u_cell (
      .clk       (clk),
      .en        (cell_en),
      .ctrl      (op_ctrl),
      .new_value (op_value),
      .prev_data (prev_d),
      .next_data (next_d),
      .data      (cell_data[i]),
      .tap       (cell_tap[i])
    );
  end

  // First merge level, captured before the cells shift
  for (genvar g = 0; g < NG; g++) begin : g_grp
    localparam int unsigned Base = g * GS;
    localparam int unsigned N    = ((DEPTH - Base) < GS) ? (DEPTH - Base) : GS;
    pol_group #(
      .N (N)
    ) u_grp (
      .clk    (clk),
      .en     (cell_en),
      .taps   (cell_tap[Base +: N]),
      .merged (grp_data[g])
    );
  end

  // Final merge
  always_comb begin
    read_merged = '0;
    for (int g = 0; g < NG; g++) begin
      read_merged = read_merged | grp_data[g];
    end
  end

  assign read_value = op_rd ? read_merged : '0;

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {7'd0, PosW'(count), op_status, read_value};
    end
  end

`ifndef SYNTH
  // The list never holds more than its capacity
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("entry count above capacity");

  // A flagged request leaves the count alone
  a_flag_no_change: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EXEC && op_status != STAT_OK) |=> $stable(count))
    else $error("flagged request changed the count");

  // A full report only goes out when the list is at capacity
  a_full_report: assert property (@(posedge clk) disable iff (rst)
    (out_load && op_status == STAT_FULL) |-> full)
    else $error("full status with room left");

  // Read value is zero unless a successful read or delete produced it
  a_read_zero: assert property (@(posedge clk) disable iff (rst)
    (out_load && !op_rd) |=> (m_tdata[31:0] == '0))
    else $error("nonzero read value on insert or flagged request");
`endif

endmodule

`default_nettype wire

### dv/tb.sv
// Self-checking bench for positional_ordered_list: a queued stream driver, an output
// monitor and a shadow list that predicts every result word. Depends on pol_pkg and the RTL.
`timescale 1ns / 100ps

module tb;
  import pol_pkg::*;

  localparam int ListDepth = 64;
  localparam int NumWords = 1900;
  localparam int HoldCycles = 400;
  localparam int DrainCycles = 50;
  // Command code the block has no operation for
  localparam logic [1:0] CmdUnused = 2'd3;

  // Request word, packed lsb first as on s_tdata
  typedef struct packed {
    logic [31:0] val;
    logic [6:0]  pos;
    logic [1:0]  cmd;
  } list_req_t;

  // Result word, packed lsb first as on m_tdata
  typedef struct packed {
    logic [6:0]  count;
    logic [1:0]  status;
    logic [31:0] rd_val;
  } list_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;

  list_req_t    pending_requests[$];
  list_result_t expected_results[$];

  // Shadow copy of the list
  logic [31:0] shadow_list[ListDepth];
  int          shadow_count = 0;

  int n_words_in = 0;
  int n_errors = 0;
  int burst_left = 0;
  int gap_left = 0;
  int hold_left = 0;
  int holds_done = 0;
  int pattern_left = 0;
  int stall_pct = 0;
  int gen_count = 0;

  positional_ordered_list #(.DEPTH(ListDepth)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Apply one request to the shadow list and return the word the block should send
  function automatic list_result_t apply_to_shadow_list(logic [1:0] cmd, logic [6:0] pos,
                                                        logic [31:0] val);
    list_result_t res;
    int idx;
    int i;
    res = '0;
    res.status = STAT_OK;
    idx = int'(pos) - 1;
    if (cmd == CMD_INSERT) begin
      // full list wins over a bad position
      if (shadow_count >= ListDepth) begin
        res.status = STAT_FULL;
      end else if (pos == 0 || int'(pos) > shadow_count + 1) begin
        res.status = STAT_RANGE;
      end else begin
        for (i = shadow_count; i > idx; i--) shadow_list[i] = shadow_list[i-1];
        shadow_list[idx] = val;
        shadow_count++;
      end
    end else if (cmd == CMD_DELETE || cmd == CMD_READ) begin
      if (pos == 0 || int'(pos) > shadow_count) begin
        res.status = STAT_RANGE;
      end else begin
        res.rd_val = shadow_list[idx];
        if (cmd == CMD_DELETE) begin
          for (i = idx; i + 1 < shadow_count; i++) shadow_list[i] = shadow_list[i+1];
          shadow_count--;
        end
      end
    end else begin
      res.status = STAT_RANGE;
    end
    res.count = 7'(shadow_count);
    return res;
  endfunction

  // Queue a request; gen_count follows the list size so positions can be aimed
  task automatic queue_request(logic [1:0] cmd, logic [6:0] pos, logic [31:0] val);
    list_req_t req;
    req.cmd = cmd;
    req.pos = pos;
    req.val = val;
    pending_requests.push_back(req);
    if (cmd == CMD_INSERT && gen_count < ListDepth && pos != 0 && int'(pos) <= gen_count + 1)
      gen_count++;
    else if (cmd == CMD_DELETE && pos != 0 && int'(pos) <= gen_count)
      gen_count--;
  endtask

  // Driver: bursts of words with random gaps, prediction on every accepted word
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata <= '0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      if (s_tvalid && s_tready) begin
        expected_results.push_back(apply_to_shadow_list(s_tdata[1:0], s_tdata[8:2],
                                                         s_tdata[40:9]));
        n_words_in <= n_words_in + 1;
      end
      if (!s_tvalid || s_tready) begin
        if (gap_left > 0) begin
          s_tvalid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (pending_requests.size() > 0) begin
          s_tdata <= {7'b0, pending_requests.pop_front()};
          s_tvalid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 40);
            gap_left <= ($urandom_range(9) < 4) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: stall rate changes every stretch; two long holds back up the block
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      hold_left <= 0;
      pattern_left <= 0;
      stall_pct <= 0;
    end else if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if ((holds_done == 0 && n_words_in >= 300) ||
                 (holds_done == 1 && n_words_in >= 1200)) begin
      m_tready <= 1'b0;
      hold_left <= HoldCycles;
      holds_done <= holds_done + 1;
    end else begin
      if (pattern_left == 0) begin
        case ($urandom_range(3))
          0: stall_pct <= 0;
          1: stall_pct <= 10;
          2: stall_pct <= 50;
          default: stall_pct <= 85;
        endcase
        pattern_left <= $urandom_range(16, 128);
      end else begin
        pattern_left <= pattern_left - 1;
      end
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Monitor: compare each result word with the oldest prediction
  always @(posedge clk) begin
    list_result_t got;
    list_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = list_result_t'(m_tdata[40:0]);
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result word, expected none, got %h", $time, m_tdata);
        n_errors++;
      end else begin
        want = expected_results.pop_front();
        if (got.rd_val !== want.rd_val) begin
          $display("%0t: read_value mismatch, expected %h, got %h", $time, want.rd_val,
                   got.rd_val);
          n_errors++;
        end
        if (got.status !== want.status) begin
          $display("%0t: status mismatch, expected %0d, got %0d", $time, want.status,
                   got.status);
          n_errors++;
        end
        if (got.count !== want.count) begin
          $display("%0t: entry_count mismatch, expected %0d, got %0d", $time, want.count,
                   got.count);
          n_errors++;
        end
      end
    end
  end

  // Stimulus, reset and end of run
  initial begin
    int phase;
    int phase_len;
    int roll;
    int hi;
    logic [1:0] cmd;
    logic [6:0] pos;

    // Directed: empty list, bad positions, head/middle/tail, extremes, unused command
    queue_request(CMD_READ, 7'd1, 32'h0);
    queue_request(CMD_DELETE, 7'd1, 32'h0);
    queue_request(CMD_DELETE, 7'd0, 32'h0);
    queue_request(CMD_INSERT, 7'd0, 32'h1234_5678);
    queue_request(CMD_INSERT, 7'd2, 32'h1234_5678);
    queue_request(CMD_INSERT, 7'd1, 32'h7FFF_FFFF);
    queue_request(CMD_INSERT, 7'd2, 32'h8000_0000);
    queue_request(CMD_INSERT, 7'd1, 32'h0000_0000);
    queue_request(CMD_INSERT, 7'd3, 32'hFFFF_FFFF);
    queue_request(CMD_READ, 7'd4, 32'hFFFF_FFFF);
    queue_request(CMD_READ, 7'd1, 32'h0);
    queue_request(CMD_READ, 7'd5, 32'h0);
    queue_request(CMD_READ, 7'd127, 32'h0);
    queue_request(CmdUnused, 7'd1, 32'hFFFF_FFFF);
    queue_request(CMD_INSERT, 7'd127, 32'hA5A5_A5A5);
    queue_request(CMD_DELETE, 7'd2, 32'h0);
    queue_request(CMD_DELETE, 7'd3, 32'h0);
    queue_request(CMD_DELETE, 7'd1, 32'h0);
    queue_request(CMD_DELETE, 7'd2, 32'h0);
    queue_request(CMD_READ, 7'd1, 32'h0);
    queue_request(CMD_DELETE, 7'd1, 32'h0);
    queue_request(CmdUnused, 7'd127, 32'h0);

    // Random: phases that fill (reaching the full list), drain, or mix
    phase = 0;
    while (pending_requests.size() < NumWords) begin
      phase_len = $urandom_range(60, 200);
      repeat (phase_len) begin
        roll = $urandom_range(99);
        if (roll < 8) begin
          // noise: any command, any position
          queue_request(2'($urandom_range(3)), 7'($urandom_range(127)), $urandom);
        end else begin
          roll = $urandom_range(99);
          case (phase % 3)
            0: cmd = (roll < 85) ? CMD_INSERT : (roll < 90) ? CMD_DELETE : CMD_READ;
            1: cmd = (roll < 10) ? CMD_INSERT : (roll < 85) ? CMD_DELETE : CMD_READ;
            default: cmd = (roll < 35) ? CMD_INSERT : (roll < 65) ? CMD_DELETE : CMD_READ;
          endcase
          hi = (cmd == CMD_INSERT) ? gen_count + 1 : gen_count;
          if (hi < 1) hi = 1;
          case ($urandom_range(3))
            0: pos = 7'd1;
            1: pos = 7'(hi);
            default: pos = 7'($urandom_range(1, hi));
          endcase
          queue_request(cmd, pos, $urandom);
        end
      end
      phase++;
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (pending_requests.size() != 0 || s_tvalid) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (n_errors == 0 && expected_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
